[hdl/assert_macros.svh]
// Assertion macros used by the checker module of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that must hold outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked during reset as well.
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/wmia_pkg.sv]
// Package for the width-masked integer ALU: opcodes, transfer structs, helpers.
// No dependencies.
`default_nettype none
package wmia_pkg;

    localparam int WMIA_DATA_WIDTH = 64;

    localparam logic [5:0] OP_NOT    = 6'd0;
    localparam logic [5:0] OP_ABS    = 6'd1;
    localparam logic [5:0] OP_TRUNC  = 6'd2;
    localparam logic [5:0] OP_CLZ    = 6'd3;
    localparam logic [5:0] OP_CTZ    = 6'd4;
    localparam logic [5:0] OP_BSWAP  = 6'd5;
    localparam logic [5:0] OP_SLP    = 6'd6;
    localparam logic [5:0] OP_PREINC = 6'd7;
    localparam logic [5:0] OP_POSTINC = 6'd8;
    localparam logic [5:0] OP_PREDEC = 6'd9;
    localparam logic [5:0] OP_POSTDEC = 6'd10;
    localparam logic [5:0] OP_ADD    = 6'd11;
    localparam logic [5:0] OP_SUB    = 6'd12;
    localparam logic [5:0] OP_MUL    = 6'd13;
    localparam logic [5:0] OP_SDIV   = 6'd14;
    localparam logic [5:0] OP_UDIV   = 6'd15;
    localparam logic [5:0] OP_SREM   = 6'd16;
    localparam logic [5:0] OP_UREM   = 6'd17;
    localparam logic [5:0] OP_XOR    = 6'd18;
    localparam logic [5:0] OP_AND    = 6'd19;
    localparam logic [5:0] OP_OR     = 6'd20;
    localparam logic [5:0] OP_LSR    = 6'd21;
    localparam logic [5:0] OP_ASR    = 6'd22;
    localparam logic [5:0] OP_SHL    = 6'd23;
    localparam logic [5:0] OP_ROL    = 6'd24;
    localparam logic [5:0] OP_ROR    = 6'd25;
    localparam logic [5:0] OP_SUBREG = 6'd26;
    localparam logic [5:0] OP_POSTMOD = 6'd27;
    localparam logic [5:0] OP_PREMOD = 6'd28;
    localparam logic [5:0] OP_MADD   = 6'd29;
    localparam logic [5:0] OP_ZEXT   = 6'd30;
    localparam logic [5:0] OP_SEXT   = 6'd31;

    typedef enum logic [1:0] {
        SEL_VALUE,
        SEL_QUO,
        SEL_REM
    } sel_t;

    // Side data that travels alongside the divider.
    typedef struct packed {
        sel_t        sel;
        logic        neg;
        logic        ok;
        logic [1:0]  width_code;
        logic [63:0] value;
    } side_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] d;
    } div_in_t;

    function automatic logic [63:0] wmia_low_mask(input logic [6:0] n);
        logic [63:0] r;
        if (n[6]) begin
            r = '1;
        end else begin
            r = (64'd1 << n[5:0]) - 64'd1;
        end
        return r;
    endfunction

    function automatic logic [6:0] wmia_bits(input logic [1:0] code);
        return 7'd8 << code;
    endfunction

    function automatic logic [63:0] wmia_width_mask(input logic [1:0] code);
        return wmia_low_mask(wmia_bits(code));
    endfunction

endpackage
`default_nettype wire

[hdl/wmia_front.sv]
// Front stages: decode, simple operations, multiply partial products and divider
// setup, then the multiply sum. Depends on wmia_pkg.
`default_nettype none
module wmia_front import wmia_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [5:0]  kind,
    input  wire logic [1:0]  width_code,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic [63:0] operand_c,
    output logic             out_valid,
    output side_t            out_side,
    output div_in_t          out_div
);

    logic        f1_valid_reg;
    side_t       f1_side_reg,  f1_side_next;
    div_in_t     f1_div_reg,   f1_div_next;
    logic        f1_mul_reg,   f1_mul_next;
    logic [63:0] f1_p0_reg,    f1_p0_next;
    logic [31:0] f1_p1_reg,    f1_p1_next;
    logic [31:0] f1_p2_reg,    f1_p2_next;
    logic [63:0] f1_c_reg,     f1_c_next;

    logic        f2_valid_reg;
    side_t       f2_side_reg,  f2_side_next;
    div_in_t     f2_div_reg;

    always_comb begin
        logic [63:0] a, b, t, v, fm;
        logic [6:0]  w, r, rr;
        logic [5:0]  hi, lo;
        logic        ok;
        a  = operand_a;
        b  = operand_b;
        w  = wmia_bits(width_code);
        t  = a & wmia_width_mask(width_code);
        hi = '0;
        lo = '0;
        for (int i = 0; i < 64; i++) begin
            if (t[i]) hi = 6'(i);
        end
        for (int i = 63; i >= 0; i--) begin
            if (t[i]) lo = 6'(i);
        end
        r  = {1'b0, b[5:0]} & (w - 7'd1);
        rr = (w - r) & (w - 7'd1);
        fm = wmia_low_mask(b[6:0]);
        v  = '0;
        ok = 1'b1;
        f1_mul_next = 1'b0;
        f1_div_next.n = a;
        f1_div_next.d = b;
        f1_side_next.sel = SEL_VALUE;
        f1_side_next.neg = 1'b0;
        case (kind)
            OP_NOT: v = ~a;
            OP_ABS: v = a[63] ? 64'd0 - a : a;
            OP_TRUNC, OP_SLP, OP_POSTINC, OP_POSTDEC, OP_POSTMOD: v = a;
            OP_CLZ: begin
                ok = |t;
                v  = 64'(w - 7'd1 - {1'b0, hi});
            end
            OP_CTZ: begin
                ok = |t;
                v  = 64'(lo);
            end
            OP_BSWAP: begin
                case (width_code)
                    2'd0: v = {56'd0, a[7:0]};
                    2'd1: v = {48'd0, a[7:0], a[15:8]};
                    2'd2: begin
                        for (int k = 0; k < 4; k++) v[8*(3-k) +: 8] = a[8*k +: 8];
                    end
                    default: begin
                        for (int k = 0; k < 8; k++) v[8*(7-k) +: 8] = a[8*k +: 8];
                    end
                endcase
            end
            OP_PREINC: v = a + (64'd1 << width_code);
            OP_PREDEC: v = a - (64'd1 << width_code);
            OP_ADD:    v = a + b;
            OP_SUB:    v = a - b;
            OP_MUL, OP_MADD: f1_mul_next = 1'b1;
            OP_SDIV, OP_SREM: begin
                ok = |b;
                f1_div_next.n = a[63] ? 64'd0 - a : a;
                f1_div_next.d = b[63] ? 64'd0 - b : b;
                f1_side_next.sel = (kind == OP_SDIV) ? SEL_QUO : SEL_REM;
                f1_side_next.neg = (kind == OP_SDIV) ? (a[63] ^ b[63]) : a[63];
            end
            OP_UDIV, OP_UREM: begin
                ok = |b;
                f1_side_next.sel = (kind == OP_UDIV) ? SEL_QUO : SEL_REM;
            end
            OP_XOR: v = a ^ b;
            OP_AND: v = a & b;
            OP_OR:  v = a | b;
            OP_LSR, OP_ASR, OP_SHL: begin
                ok = ~|b[63:6];
                if (kind == OP_LSR)      v = a >> b[5:0];
                else if (kind == OP_SHL) v = a << b[5:0];
                else                     v = 64'($signed(a) >>> b[5:0]);
            end
            OP_ROL, OP_ROR: begin
                if (b == 64'd0 || b[63]) begin
                    v = a;
                end else if (kind == OP_ROL) begin
                    v = (t << r) | (t >> (w - r));
                end else begin
                    v = (t << rr) | (t >> (w - rr));
                end
            end
            OP_SUBREG: begin
                ok = ~|b[63:3];
                v  = a >> {b[2:0], 3'b000};
            end
            OP_PREMOD: v = b;
            OP_ZEXT, OP_SEXT: begin
                ok = ~|operand_c[63:6] && (b <= 64'd64);
                v  = (a >> operand_c[5:0]) & fm;
                if (kind == OP_SEXT && b[6:0] != 7'd0 && !b[6] && v[b[5:0] - 6'd1]) begin
                    v = v | ~fm;
                end
            end
            default: ok = 1'b0;
        endcase
        f1_side_next.ok = ok;
        f1_side_next.width_code = width_code;
        f1_side_next.value = v;
        f1_p0_next = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        f1_p1_next = 32'(a[31:0] * b[63:32]);
        f1_p2_next = 32'(a[63:32] * b[31:0]);
        f1_c_next  = (kind == OP_MADD) ? operand_c : 64'd0;
    end

    always_comb begin
        f2_side_next = f1_side_reg;
        if (f1_mul_reg) begin
            f2_side_next.value = f1_p0_reg + {f1_p1_reg + f1_p2_reg, 32'd0} + f1_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_side_reg <= f1_side_next;
            f1_div_reg  <= f1_div_next;
            f1_mul_reg  <= f1_mul_next;
            f1_p0_reg   <= f1_p0_next;
            f1_p1_reg   <= f1_p1_next;
            f1_p2_reg   <= f1_p2_next;
            f1_c_reg    <= f1_c_next;
            f2_side_reg <= f2_side_next;
            f2_div_reg  <= f1_div_reg;
        end
    end

    assign out_valid = f2_valid_reg;
    assign out_side  = f2_side_reg;
    assign out_div   = f2_div_reg;

endmodule
`default_nettype wire

[hdl/wmia_divpipe.sv]
// Pipelined restoring divider, one quotient bit per stage, carrying side data.
// Depends on wmia_pkg.
`default_nettype none
module wmia_divpipe import wmia_pkg::*; #(
    parameter int DATA_WIDTH = WMIA_DATA_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  side_t                      in_side,
    input  div_in_t                    in_div,
    output logic                       out_valid,
    output side_t                      out_side,
    output logic [DATA_WIDTH-1:0]      quo,
    output logic [DATA_WIDTH-1:0]      rem
);

    logic                  valid_reg [DATA_WIDTH];
    side_t                 side_reg  [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] n_reg     [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] r_reg     [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] d_reg     [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] n_next    [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] r_next    [DATA_WIDTH];

    always_comb begin
        logic [DATA_WIDTH-1:0] np, rp, dp;
        logic [DATA_WIDTH:0]   t;
        logic                  qb;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            np = (i == 0) ? DATA_WIDTH'(in_div.n) : n_reg[(i == 0) ? 0 : i - 1];
            rp = (i == 0) ? '0 : r_reg[(i == 0) ? 0 : i - 1];
            dp = (i == 0) ? DATA_WIDTH'(in_div.d) : d_reg[(i == 0) ? 0 : i - 1];
            t  = {rp, np[DATA_WIDTH-1]};
            qb = (t >= {1'b0, dp});
            r_next[i] = qb ? DATA_WIDTH'(t - {1'b0, dp}) : t[DATA_WIDTH-1:0];
            n_next[i] = {np[DATA_WIDTH-2:0], qb};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DATA_WIDTH; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DATA_WIDTH; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            d_reg[0]    <= DATA_WIDTH'(in_div.d);
            for (int i = 1; i < DATA_WIDTH; i++) begin
                side_reg[i] <= side_reg[i-1];
                d_reg[i]    <= d_reg[i-1];
            end
            for (int i = 0; i < DATA_WIDTH; i++) begin
                n_reg[i] <= n_next[i];
                r_reg[i] <= r_next[i];
            end
        end
    end

    assign out_valid = valid_reg[DATA_WIDTH-1];
    assign out_side  = side_reg[DATA_WIDTH-1];
    assign quo       = n_reg[DATA_WIDTH-1];
    assign rem       = r_reg[DATA_WIDTH-1];

endmodule
`default_nettype wire

[hdl/wmia_back.sv]
// Back stage: pick the result, apply the divide sign, mask to width (zero if not ok).
// Depends on wmia_pkg.
`default_nettype none
module wmia_back import wmia_pkg::*; #(
    parameter int DATA_WIDTH = WMIA_DATA_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  side_t                      in_side,
    input  wire logic [DATA_WIDTH-1:0] quo,
    input  wire logic [DATA_WIDTH-1:0] rem,
    output logic                       out_valid,
    output logic [DATA_WIDTH-1:0]      out_value,
    output logic                       out_ok
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic                  ok_reg;

    always_comb begin
        logic [DATA_WIDTH-1:0] v;
        case (in_side.sel)
            SEL_QUO: v = quo;
            SEL_REM: v = rem;
            default: v = DATA_WIDTH'(in_side.value);
        endcase
        if (in_side.sel != SEL_VALUE && in_side.neg) v = '0 - v;
        value_next = in_side.ok ? (v & DATA_WIDTH'(wmia_width_mask(in_side.width_code))) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
            ok_reg    <= in_side.ok;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_ok    = ok_reg;

endmodule
`default_nettype wire

[hdl/width_masked_integer_alu.sv]
// Top level of the width-masked integer ALU: front, divider pipeline, back, skid.
// Depends on wmia_pkg, wmia_front, wmia_divpipe, wmia_back.
//
// Usage:
//   Input channel s_valid/s_ready carries kind, width_code and three 64-bit
//   operands; output channel m_valid/m_ready carries m_value and m_ok.
//   Every operation, simple or not, flows through the same pipeline: two
//   front stages, one divider stage per data bit (64), a result stage and an
//   output register, 68 register stages in all. Throughput is one operation
//   per cycle while s_ready is high; the 64 one-bit divider stages set the
//   latency.
//   Reset (aresetn low, synchronous) empties every stage and the output.
//   When the receiver stalls, the output register holds its result and a
//   skid register takes one more; then s_ready drops and the whole pipeline
//   holds until the skid register drains.
`default_nettype none
module width_masked_integer_alu import wmia_pkg::*; #(
    parameter int DATA_WIDTH = WMIA_DATA_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [5:0]            s_kind,
    input  wire logic [1:0]            s_width_code,
    input  wire logic [DATA_WIDTH-1:0] s_operand_a,
    input  wire logic [DATA_WIDTH-1:0] s_operand_b,
    input  wire logic [DATA_WIDTH-1:0] s_operand_c,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_WIDTH-1:0]      m_value,
    output logic                       m_ok
);

    logic                  en;
    logic                  fr_valid;
    side_t                 fr_side;
    div_in_t               fr_div;
    logic                  dv_valid;
    side_t                 dv_side;
    logic [DATA_WIDTH-1:0] dv_quo, dv_rem;
    logic                  bk_valid;
    logic [DATA_WIDTH-1:0] bk_value;
    logic                  bk_ok;

    logic                  out_valid_reg, skid_valid_reg;
    logic [DATA_WIDTH-1:0] out_value_reg, skid_value_reg;
    logic                  out_ok_reg,    skid_ok_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    wmia_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .kind       (s_kind),
        .width_code (s_width_code),
        .operand_a  (64'(s_operand_a)),
        .operand_b  (64'(s_operand_b)),
        .operand_c  (64'(s_operand_c)),
        .out_valid  (fr_valid),
        .out_side   (fr_side),
        .out_div    (fr_div)
    );

    wmia_divpipe #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_div    (fr_div),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quo       (dv_quo),
        .rem       (dv_rem)
    );

    wmia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_side   (dv_side),
        .quo       (dv_quo),
        .rem       (dv_rem),
        .out_valid (bk_valid),
        .out_value (bk_value),
        .out_ok    (bk_ok)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the skid register once the output transfer happens
            if (m_ready) skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= bk_valid;
        end else if (bk_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_value_reg <= skid_value_reg;
                out_ok_reg    <= skid_ok_reg;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_value_reg <= bk_value;
            out_ok_reg    <= bk_ok;
        end else begin
            skid_value_reg <= bk_value;
            skid_ok_reg    <= bk_ok;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;
    assign m_ok    = out_ok_reg;

endmodule
`default_nettype wire

[hdl/wmia_checker.sv]
// Port-level checker for the width-masked integer ALU, bound to the top level.
// Depends on assert_macros.svh and wmia_pkg.
`default_nettype none
`include "assert_macros.svh"
module wmia_checker import wmia_pkg::*; #(
    parameter int DATA_WIDTH = WMIA_DATA_WIDTH
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [DATA_WIDTH-1:0] m_value,
    input wire logic                  m_ok
);

    `ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)
    `ASSERT_IMPLY(a_fail_zero, aclk, aresetn, m_valid && !m_ok, m_value == '0)
    `ASSERT_IMPLY(a_stall_only_full, aclk, aresetn, !s_ready, m_valid)
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_value) && $stable(m_ok))
    `ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid)

endmodule

bind width_masked_integer_alu wmia_checker #(.DATA_WIDTH(DATA_WIDTH)) u_wmia_checker (.*);
`default_nettype wire
